// ----- src/crc8_frame_decoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// CRC-8 frame decoder assertion macros
// Shared concurrent assertion forms for the frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef CRC8_FRAME_DECODER_UNIT_MACROS_SVH
`define CRC8_FRAME_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CFD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame decoder same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame decoder next-cycle check failed");

`endif

// ----- src/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// CRC-8 frame decoder package
// Types, codes, reset values and the byte-wise CRC-8 step.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int DEFAULT_MAX_PAYLOAD = 32;
  localparam int MIN_FRAME           = 5;

  localparam logic [7:0] SYNC_RESET = 8'd170;
  localparam logic [7:0] END_RESET  = 8'd85;
  localparam logic [7:0] POLY_RESET = 8'd7;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SYNC = 2'd0,
    REG_END  = 2'd1,
    REG_POLY = 2'd2
  } reg_index_t;

  // Frame status codes, also used as the first positional error.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_SYNC  = 3'd2,
    ST_LEN_OVER  = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_BAD_END   = 3'd5,
    ST_BAD_CRC   = 3'd6
  } status_t;

  // Result beat payload, packed with payload_byte in the lowest bits.
  typedef struct packed {
    logic [1:0] pad;
    status_t    status;
    logic [5:0] payload_length;
    logic [7:0] command_code;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
  } out_data_t;

  // One byte through an MSB-first CRC-8, top bit of the polynomial implied.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/crc8_frame_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// CRC-8 frame decoder
// Decodes SYNC, LEN, CMD, payload, CRC, END frames from a byte stream and
// emits the payload bytes of a good frame followed by one status beat.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                Contents
//   s_*       in         s_tvalid / s_tready      tdata: data byte, tlast: end of buffer
//   m_*       out        m_tvalid / m_tready      tdata: result fields, tuser: kind,
//                                                 tlast: status beat
//   cfg_*     in         cfg_valid / cfg_ready    register index and write data
//
// A buffer streams in at one beat per clock while the emitter leaves s_tready
// high. The last byte of a buffer hands its verdict to the emitter, which
// sends one result beat per cycle while m_tready allows it: LEN payload beats
// read from the payload memory and then the status beat, so a good frame
// gives LEN + 1 result beats and a failed frame one. While payload beats are
// still being read from the memory the input is held off; the next buffer
// may start in the cycle in which the status beat leaves the emitter. Reset
// is synchronous and active high and restores the register defaults and an
// empty frame; the payload memory is not cleared. A stall on m_tready holds
// the output register and, through the emitter, eventually the input.
// ----------------------------------------------------------------------------
`include "crc8_frame_decoder_unit_macros.svh"

module crc8_frame_decoder_unit #(
  parameter int MAX_PAYLOAD = cfd_pkg::DEFAULT_MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_of_buffer
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] payload_byte, [12:8] byte_index,
                                 // [20:13] command_code, [26:21] payload_length,
                                 // [29:27] status, [31:30] zero
  output logic        m_tuser,   // item_kind
  output logic        m_tlast,   // last_item
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Address width of the payload memory and width of a payload count.
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int IW = $clog2(MAX_PAYLOAD + 1);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always accepted; an index beyond the
  // register list is dropped.
  // --------------------------------------------------------------------------
  logic [7:0] sync_value;
  logic [7:0] end_value;
  logic [7:0] crc_polynomial;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value     <= cfd_pkg::SYNC_RESET;
      end_value      <= cfd_pkg::END_RESET;
      crc_polynomial <= cfd_pkg::POLY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cfd_pkg::REG_SYNC: sync_value     <= cfg_data;
        cfd_pkg::REG_END:  end_value      <= cfg_data;
        cfd_pkg::REG_POLY: crc_polynomial <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame parser. The state registers hold everything learned from the bytes
  // of the current buffer; the next values below are what one more byte
  // makes of them.
  // --------------------------------------------------------------------------
  logic [7:0]       byte_position, byte_position_next;
  logic [7:0]       running_crc, running_crc_next;
  logic [7:0]       frame_length, frame_length_next;
  logic [7:0]       frame_command, frame_command_next;
  logic [7:0]       received_crc, received_crc_next;
  cfd_pkg::status_t first_error, first_error_next;
  cfd_pkg::status_t frame_status;

  logic             in_fire;
  logic [7:0]       crc_step;
  logic [8:0]       pos_wide;
  logic [8:0]       len_wide;
  logic [8:0]       byte_count;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;

  assign in_fire    = s_tvalid && s_tready;
  assign crc_step   = cfd_pkg::crc8_byte(running_crc, s_tdata, crc_polynomial);
  assign pos_wide   = {1'b0, byte_position};
  assign len_wide   = {1'b0, frame_length};
  assign byte_count = pos_wide + 9'd1;
  assign mem_waddr  = AW'(byte_position - 8'd3);

  always_comb begin
    running_crc_next   = running_crc;
    frame_length_next  = frame_length;
    frame_command_next = frame_command;
    received_crc_next  = received_crc;
    first_error_next   = first_error;
    mem_we             = 1'b0;

    // Once sync or length has failed the rest of the buffer is only counted.
    if (first_error == cfd_pkg::ST_OK) begin
      if (byte_position == 8'd0) begin
        if (s_tdata != sync_value) begin
          first_error_next = cfd_pkg::ST_BAD_SYNC;
        end
      end else if (byte_position == 8'd1) begin
        frame_length_next = s_tdata;
        if (s_tdata > 8'(MAX_PAYLOAD)) begin
          first_error_next = cfd_pkg::ST_LEN_OVER;
        end else begin
          running_crc_next = crc_step;
        end
      end else if (byte_position == 8'd2) begin
        frame_command_next = s_tdata;
        running_crc_next   = crc_step;
      end else if (pos_wide < len_wide + 9'd3) begin
        mem_we           = in_fire;
        running_crc_next = crc_step;
      end else if (pos_wide == len_wide + 9'd3) begin
        received_crc_next = s_tdata;
      end else if (pos_wide == len_wide + 9'd4) begin
        if (s_tdata != end_value) begin
          first_error_next = cfd_pkg::ST_BAD_END;
        end
      end
    end

    byte_position_next = (byte_position == 8'hFF) ? byte_position
                                                   : byte_position + 8'd1;

    // Verdict on the buffer if this byte is its last, in priority order.
    if (byte_count < 9'(cfd_pkg::MIN_FRAME)) begin
      frame_status = cfd_pkg::ST_SHORT;
    end else if (first_error_next == cfd_pkg::ST_BAD_SYNC) begin
      frame_status = cfd_pkg::ST_BAD_SYNC;
    end else if (first_error_next == cfd_pkg::ST_LEN_OVER) begin
      frame_status = cfd_pkg::ST_LEN_OVER;
    end else if (byte_count < 9'(cfd_pkg::MIN_FRAME) + {1'b0, frame_length_next}) begin
      frame_status = cfd_pkg::ST_TRUNCATED;
    end else if (first_error_next == cfd_pkg::ST_BAD_END) begin
      frame_status = cfd_pkg::ST_BAD_END;
    end else if (received_crc_next != running_crc_next) begin
      frame_status = cfd_pkg::ST_BAD_CRC;
    end else begin
      frame_status = cfd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_crc   <= '0;
      frame_length  <= '0;
      frame_command <= '0;
      received_crc  <= '0;
      first_error   <= cfd_pkg::ST_OK;
    end else if (in_fire) begin
      if (s_tlast) begin
        // The buffer is finished: start the next one from a clean frame.
        byte_position <= '0;
        running_crc   <= '0;
        frame_length  <= '0;
        frame_command <= '0;
        received_crc  <= '0;
        first_error   <= cfd_pkg::ST_OK;
      end else begin
        byte_position <= byte_position_next;
        running_crc   <= running_crc_next;
        frame_length  <= frame_length_next;
        frame_command <= frame_command_next;
        received_crc  <= received_crc_next;
        first_error   <= first_error_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload memory: one write port from the parser, one registered read port
  // for the emitter.
  // --------------------------------------------------------------------------
  logic [7:0]    payload_mem [MAX_PAYLOAD];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_mem[mem_waddr] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= payload_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Result emitter. It walks the payload of a good frame and then sends the
  // status beat. The read address runs one step ahead so that rd_data always
  // holds the entry for emit_idx.
  // --------------------------------------------------------------------------
  logic             launch;
  logic             emit_active;
  logic [IW-1:0]    emit_idx;
  logic [IW-1:0]    emit_idx_next;
  logic [IW-1:0]    emit_pay;
  logic [7:0]       emit_cmd;
  logic [5:0]       emit_len;
  cfd_pkg::status_t emit_st;
  logic             emit_fire;
  logic             emit_is_pay;
  logic             frame_ok;

  assign launch      = in_fire && s_tlast;
  assign frame_ok    = (frame_status == cfd_pkg::ST_OK);
  assign emit_fire   = emit_active && (!m_tvalid || m_tready);
  assign emit_is_pay = (emit_idx < emit_pay);

  // The input waits while payload beats remain to be read and while the status beat waits to leave.
  assign s_tready = !emit_active || (emit_fire && !emit_is_pay);

  always_comb begin
    if (launch) begin
      emit_idx_next = '0;
    end else if (emit_fire && emit_is_pay) begin
      emit_idx_next = emit_idx + IW'(1);
    end else begin
      emit_idx_next = emit_idx;
    end
  end

  assign rd_addr = emit_idx_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_active <= 1'b0;
    end else if (launch) begin
      emit_active <= 1'b1;
    end else if (emit_fire && !emit_is_pay) begin
      emit_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    emit_idx <= emit_idx_next;
    if (launch) begin
      emit_pay <= frame_ok ? frame_length_next[IW-1:0] : '0;
      emit_cmd <= frame_ok ? frame_command_next : 8'd0;
      emit_len <= frame_ok ? frame_length_next[5:0] : 6'd0;
      emit_st  <= frame_status;
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  cfd_pkg::out_data_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data.pad            <= 2'b00;
      out_data.command_code   <= emit_cmd;
      out_data.payload_length <= emit_len;
      if (emit_is_pay) begin
        out_data.payload_byte <= rd_data;
        out_data.byte_index   <= 5'(emit_idx);
        out_data.status       <= cfd_pkg::ST_OK;
        m_tuser               <= 1'b0;
        m_tlast               <= 1'b0;
      end else begin
        out_data.payload_byte <= 8'd0;
        out_data.byte_index   <= 5'd0;
        out_data.status       <= emit_st;
        m_tuser               <= 1'b1;
        m_tlast               <= 1'b1;
      end
    end
  end

  assign m_tdata = out_data;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // No new byte may enter while the memory still has payload beats to give.
  `CFD_ASSERT_SAME(a_no_input_during_payload, in_fire, !(emit_active && emit_is_pay))
  // The last byte of a buffer always starts the emitter.
  `CFD_ASSERT_NEXT(a_last_starts_emitter, launch, emit_active)
  // A payload beat never carries a failure status, and its kind matches tlast.
  `CFD_ASSERT_SAME(a_payload_beat_ok, m_tvalid && !m_tuser,
                   out_data.status == cfd_pkg::ST_OK && !m_tlast)
  // The position count holds at its ceiling within a long buffer.
  `CFD_ASSERT_NEXT(a_position_saturates,
                   in_fire && !s_tlast && byte_position == 8'hFF,
                   byte_position == 8'hFF)

endmodule

// ----- dv/crc8_frame_decoder_unit_test.sv -----
// ----------------------------------------------------------------------------
// CRC-8 frame decoder regression bench
// Streams byte buffers into the decoder and checks every result beat against
// a cycle-free model of the frame rules kept inside this bench. A short table
// of hand-written buffers comes first; then random buffers follow, most of
// them well-formed frames and the rest noise or damaged frames, under several
// register settings, with random gaps and stalls on both streams outside the quiet run.
// ----------------------------------------------------------------------------
module crc8_frame_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD_MAX = cfd_pkg::DEFAULT_MAX_PAYLOAD;
  localparam int CYCLE_LIMIT = 400000;
  // Index 3 names no register, so a write to it must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // One expected result beat, field by field.
  typedef struct packed {
    logic             kind;
    logic [7:0]       payload;
    logic [4:0]       index;
    logic [7:0]       command;
    logic [5:0]       length;
    cfd_pkg::status_t verdict;
    logic             last;
  } decoded_beat_t;

  // One row of the directed table. Where pinned is set on a last byte, the
  // status beat is typed in here rather than taken from the frame model.
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             pinned;
    cfd_pkg::status_t code;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = cfd_pkg::REG_SYNC;
  logic [7:0]  cfg_data = 8'h00;

  // Travels alongside the byte beat, so the monitor sees it at the same edge.
  logic             pinned_on = 1'b0;
  cfd_pkg::status_t pinned_code = cfd_pkg::ST_OK;

  // Quiet mode switches off the random gaps and stalls on both streams.
  bit quiet = 1'b0;

  // Register values as the frame model sees them (updated on accepted writes).
  logic [7:0] reg_sync = cfd_pkg::SYNC_RESET;
  logic [7:0] reg_end  = cfd_pkg::END_RESET;
  logic [7:0] reg_poly = cfd_pkg::POLY_RESET;

  // Register values the buffer builder uses (set by the stimulus side).
  logic [7:0] use_sync = cfd_pkg::SYNC_RESET;
  logic [7:0] use_end  = cfd_pkg::END_RESET;
  logic [7:0] use_poly = cfd_pkg::POLY_RESET;

  // Frame model state.
  logic [7:0]       byte_pos = 8'd0;
  logic [7:0]       crc_acc = 8'h00;
  logic [7:0]       frame_len = 8'd0;
  logic [7:0]       frame_cmd = 8'd0;
  logic [7:0]       crc_rx = 8'd0;
  cfd_pkg::status_t first_err = cfd_pkg::ST_OK;
  logic [7:0]       payload_mem [PAYLOAD_MAX];

  decoded_beat_t pending_beats[$];

  int mismatches = 0;
  int cycle_count = 0;
  int bytes_in = 0;
  int beats_out = 0;
  int cfg_writes = 0;
  int verdicts [7] = '{default: 0};

  stim_row_t directed_rows [27] = '{
    // A single sync byte alone is too short to judge anything else.
    '{8'hAA, 1'b1, 1'b1, cfd_pkg::ST_SHORT},
    // All-ones buffer: wrong sync.
    '{8'hFF, 1'b0, 1'b0, cfd_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, cfd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, cfd_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, cfd_pkg::ST_OK},
    '{8'hFF, 1'b1, 1'b1, cfd_pkg::ST_BAD_SYNC},
    // LEN one above the maximum; the rest of the buffer is only counted.
    '{8'hAA, 1'b0, 1'b0, cfd_pkg::ST_OK}, '{8'h21, 1'b0, 1'b0, cfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, cfd_pkg::ST_OK}, '{8'h00, 1'b0, 1'b0, cfd_pkg::ST_OK},
    '{8'h00, 1'b1, 1'b1, cfd_pkg::ST_LEN_OVER},
    // Good frame: LEN 1, CMD 07, payload FF, CRC F3 under the reset polynomial.
    '{8'hAA, 1'b0, 1'b0, cfd_pkg::ST_OK}, '{8'h01, 1'b0, 1'b0, cfd_pkg::ST_OK},
    '{8'h07, 1'b0, 1'b0, cfd_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, cfd_pkg::ST_OK},
    '{8'hF3, 1'b0, 1'b0, cfd_pkg::ST_OK}, '{8'h55, 1'b1, 1'b0, cfd_pkg::ST_OK},
    // LEN 2 but the buffer stops after five bytes.
    '{8'hAA, 1'b0, 1'b0, cfd_pkg::ST_OK}, '{8'h02, 1'b0, 1'b0, cfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, cfd_pkg::ST_OK}, '{8'h00, 1'b0, 1'b0, cfd_pkg::ST_OK},
    '{8'h55, 1'b1, 1'b1, cfd_pkg::ST_TRUNCATED},
    // Empty payload, good CRC, but the closing byte is wrong.
    '{8'hAA, 1'b0, 1'b0, cfd_pkg::ST_OK}, '{8'h00, 1'b0, 1'b0, cfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, cfd_pkg::ST_OK}, '{8'h00, 1'b0, 1'b0, cfd_pkg::ST_OK},
    '{8'h00, 1'b1, 1'b1, cfd_pkg::ST_BAD_END}
  };

  crc8_frame_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // MSB-first CRC-8 over one byte; the polynomial's top bit is implied.
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    return c;
  endfunction

  // Frame model: takes one accepted byte and appends the beats it causes.
  function automatic void decode_byte(input logic [7:0] b, input logic last,
                                      ref decoded_beat_t out_beats[$]);
    int pos;
    int len;
    int count;
    cfd_pkg::status_t verdict;
    pos = int'(byte_pos);
    len = int'(frame_len);
    // Once sync or LEN has failed, or the closing byte is wrong, the
    // remaining bytes are only counted.
    if (first_err == cfd_pkg::ST_OK) begin
      if (pos == 0) begin
        if (b != reg_sync) first_err = cfd_pkg::ST_BAD_SYNC;
      end else if (pos == 1) begin
        frame_len = b;
        if (int'(b) > PAYLOAD_MAX) first_err = cfd_pkg::ST_LEN_OVER;
        else crc_acc = crc_step(crc_acc, b, reg_poly);
      end else if (pos == 2) begin
        frame_cmd = b;
        crc_acc = crc_step(crc_acc, b, reg_poly);
      end else if (pos < len + 3) begin
        if (pos - 3 < PAYLOAD_MAX) payload_mem[pos - 3] = b;
        crc_acc = crc_step(crc_acc, b, reg_poly);
      end else if (pos == len + 3) begin
        crc_rx = b;
      end else if (pos == len + 4) begin
        if (b != reg_end) first_err = cfd_pkg::ST_BAD_END;
      end
    end
    // The position count sticks at 255 on very long buffers.
    if (byte_pos != 8'd255) byte_pos = byte_pos + 8'd1;
    if (!last) return;

    count = pos + 1;
    len = int'(frame_len);
    if (count < cfd_pkg::MIN_FRAME) verdict = cfd_pkg::ST_SHORT;
    else if (first_err == cfd_pkg::ST_BAD_SYNC) verdict = cfd_pkg::ST_BAD_SYNC;
    else if (first_err == cfd_pkg::ST_LEN_OVER) verdict = cfd_pkg::ST_LEN_OVER;
    else if (count < cfd_pkg::MIN_FRAME + len) verdict = cfd_pkg::ST_TRUNCATED;
    else if (first_err == cfd_pkg::ST_BAD_END) verdict = cfd_pkg::ST_BAD_END;
    else if (crc_rx != crc_acc) verdict = cfd_pkg::ST_BAD_CRC;
    else verdict = cfd_pkg::ST_OK;
    verdicts[int'(verdict)]++;

    if (verdict == cfd_pkg::ST_OK) begin
      for (int i = 0; i < len && i < PAYLOAD_MAX; i++) begin
        out_beats.push_back('{1'b0, payload_mem[i], 5'(i), frame_cmd, 6'(len),
                              cfd_pkg::ST_OK, 1'b0});
      end
      out_beats.push_back('{1'b1, 8'h00, 5'd0, frame_cmd, 6'(len), cfd_pkg::ST_OK, 1'b1});
    end else begin
      out_beats.push_back('{1'b1, 8'h00, 5'd0, 8'h00, 6'd0, verdict, 1'b1});
    end

    // Buffer end: back to an empty frame, registers and payload kept.
    byte_pos  = 8'd0;
    crc_acc   = 8'h00;
    frame_len = 8'd0;
    frame_cmd = 8'd0;
    crc_rx    = 8'd0;
    first_err = cfd_pkg::ST_OK;
  endfunction

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic compare_beat(input decoded_beat_t want, input logic [31:0] data,
                              input logic kind, input logic last);
    cfd_pkg::out_data_t got;
    got = cfd_pkg::out_data_t'(data);
    if (kind !== want.kind)
      flag_error($sformatf("item_kind %0b, expected %0b", kind, want.kind));
    if (got.payload_byte !== want.payload)
      flag_error($sformatf("payload_byte %02h, expected %02h", got.payload_byte,
                           want.payload));
    if (got.byte_index !== want.index)
      flag_error($sformatf("byte_index %0d, expected %0d", got.byte_index, want.index));
    if (got.command_code !== want.command)
      flag_error($sformatf("command_code %02h, expected %02h", got.command_code,
                           want.command));
    if (got.payload_length !== want.length)
      flag_error($sformatf("payload_length %0d, expected %0d", got.payload_length,
                           want.length));
    if (got.status !== want.verdict)
      flag_error($sformatf("status %0d, expected %0d", got.status, want.verdict));
    if (last !== want.last)
      flag_error($sformatf("last_item %0b, expected %0b", last, want.last));
  endtask

  // Monitor: every handshake is sampled here at the clock edge, so the frame
  // model and the checks see the same values the decoder saw.
  always @(posedge clk) begin
    decoded_beat_t fresh[$];
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          cfd_pkg::REG_SYNC: reg_sync = cfg_data;
          cfd_pkg::REG_END:  reg_end  = cfg_data;
          cfd_pkg::REG_POLY: reg_poly = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        bytes_in++;
        fresh.delete();
        decode_byte(s_tdata, s_tlast, fresh);
        if (s_tlast && pinned_on)
          pending_beats.push_back('{1'b1, 8'h00, 5'd0, 8'h00, 6'd0, pinned_code, 1'b1});
        else
          foreach (fresh[i]) pending_beats.push_back(fresh[i]);
      end
      if (m_tvalid && m_tready) begin
        beats_out++;
        if (pending_beats.size() == 0)
          flag_error($sformatf("result beat %08h with nothing expected", m_tdata));
        else
          compare_beat(pending_beats.pop_front(), m_tdata, m_tuser, m_tlast);
      end
    end
  end

  // Result side: about one cycle in ten not ready, unless the bench is quiet.
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               pending_beats.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one byte beat, with an occasional gap before it, and returns at
  // the edge where it is taken.
  task automatic push_byte(input logic [7:0] b, input logic last, input logic pin,
                           input cfd_pkg::status_t code);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tdata     <= b;
    s_tlast     <= last;
    pinned_on   <= pin;
    pinned_code <= code;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_buffer(input logic [7:0] bytes[$]);
    foreach (bytes[i]) push_byte(bytes[i], i == bytes.size() - 1, 1'b0, cfd_pkg::ST_OK);
  endtask

  // Stops offering bytes and waits until every expected beat has left. The
  // first edge lets the monitor take in the byte accepted just before.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Registers change only with the decoder idle: drained, then a further wait
  // for the emitter to fall quiet.
  task automatic load_settings(input logic [7:0] sync_v, input logic [7:0] end_v,
                               input logic [7:0] poly_v);
    drain();
    repeat (8) @(posedge clk);
    write_register(cfd_pkg::REG_SYNC, sync_v);
    write_register(REG_SPARE, 8'($urandom));
    write_register(cfd_pkg::REG_END, end_v);
    write_register(cfd_pkg::REG_POLY, poly_v);
    cfg_valid <= 1'b0;
    use_sync = sync_v;
    use_end  = end_v;
    use_poly = poly_v;
    @(posedge clk);
  endtask

  // Random buffers until about budget bytes have gone in. Most are good
  // frames with random content; the rest are noise or frames with one part
  // damaged.
  task automatic random_buffers(input int budget);
    logic [7:0] frame_q[$];
    logic [7:0] acc;
    int len;
    int pick;
    int sent;
    sent = 0;
    while (sent < budget) begin
      frame_q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 9)) frame_q.push_back(8'($urandom));
      end else begin
        len = $urandom_range(0, 4);
        if ($urandom_range(0, 9) == 0) len = $urandom_range(0, PAYLOAD_MAX);
        if ($urandom_range(0, 19) == 0) len = PAYLOAD_MAX;
        frame_q.push_back(use_sync);
        frame_q.push_back(8'(len));
        frame_q.push_back(8'($urandom));
        repeat (len) frame_q.push_back(8'($urandom));
        acc = 8'h00;
        for (int i = 1; i < frame_q.size(); i++) acc = crc_step(acc, frame_q[i], use_poly);
        frame_q.push_back(acc);
        frame_q.push_back(use_end);
        if (pick >= 75) begin
          case ($urandom_range(0, 4))
            0: frame_q[0] = frame_q[0] ^ 8'($urandom_range(1, 255));
            1: frame_q[1] = 8'($urandom_range(PAYLOAD_MAX + 1, 255));
            2: repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
            3: frame_q[frame_q.size() - 2] = frame_q[frame_q.size() - 2] ^
                                             8'($urandom_range(1, 255));
            default: frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^
                                                   8'($urandom_range(1, 255));
          endcase
        end
      end
      // Bytes after the closing byte are ignored and not counted as stimulus.
      sent += frame_q.size();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
      end
      send_buffer(frame_q);
      // Now and then hold the input back until the results have all left.
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, run with the reset register values.
    foreach (directed_rows[i])
      push_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].pinned,
                directed_rows[i].code);

    // Low extremes, then high extremes with both streams quiet, then random
    // values, then the reset values written back explicitly.
    load_settings(8'h00, 8'hFF, 8'h00);
    random_buffers(40);
    quiet = 1'b1;
    load_settings(8'hFF, 8'h00, 8'hFF);
    random_buffers(40);
    quiet = 1'b0;
    load_settings(8'($urandom), 8'($urandom), 8'($urandom));
    random_buffers(40);
    load_settings(cfd_pkg::SYNC_RESET, cfd_pkg::END_RESET, cfd_pkg::POLY_RESET);
    random_buffers(40);

    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d bytes in, %0d result beats out, %0d register writes",
             bytes_in, beats_out, cfg_writes);
    $display("buffer verdicts ok/short/sync/over/trunc/end/crc: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             verdicts[0], verdicts[1], verdicts[2], verdicts[3], verdicts[4], verdicts[5],
             verdicts[6]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/cfd_pkg.sv
src/crc8_frame_decoder_unit.sv
dv/crc8_frame_decoder_unit_test.sv
